// File: design/sfr_pkg.sv
// Types and constants shared by the sensor frame receiver modules.
// No dependencies; every file but sfr_chan_if and sfr_payload_ram imports this package.
`timescale 1ns / 1ps

package sfr_pkg;

   localparam logic [7:0]  PREFIX_FIRST          = 8'hBB;
   localparam logic [7:0]  PREFIX_SECOND         = 8'hAA;
   localparam int          POS_PREFIX_FIRST      = 0;
   localparam int          POS_PREFIX_SECOND     = 1;
   localparam int          POS_ADDRESS           = 2;
   localparam int          POS_COMMAND           = 3;
   localparam int          POS_LENGTH            = 5;
   localparam int          PAYLOAD_START         = 6;
   localparam logic [15:0] DEFAULT_TIMEOUT_RESET = 16'd1000;

   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_BYTE  = 2'd1,
      REQ_TICK  = 2'd2
   } sfr_req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_PREFIX   = 2'd1,
      STATUS_CHECKSUM = 2'd2,
      STATUS_TIMEOUT  = 2'd3
   } sfr_status_type;

   typedef enum logic {
      OUT_IDLE  = 1'b0,
      OUT_DRAIN = 1'b1
   } sfr_out_state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  rx_byte;
      logic [15:0] timeout_ticks;
   } sfr_req_type;

   typedef struct packed {
      sfr_status_type frame_status;
      logic [7:0]     device_address;
      logic [7:0]     command_code;
      logic [7:0]     payload_length;
      logic [3:0]     byte_index;
      logic [7:0]     payload_byte;
      logic           last;
   } sfr_rsp_type;

   typedef struct packed {
      logic [15:0] default_timeout_ticks;
   } sfr_csr_type;

   typedef struct packed {
      logic [7:0] address;
      logic [7:0] command;
      logic [7:0] length;
   } sfr_header_type;

   typedef struct packed {
      logic           error;
      logic           good;
      sfr_status_type status;
      logic           armed;
   } sfr_event_type;

endpackage

// File: design/sfr_chan_if.sv
// Valid/ready channel carrying one payload item per handshake.
// The payload type is set per instance; uses no package.
`timescale 1ns / 1ps

interface sfr_chan_if #(
   parameter type data_type = logic
) ();
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: design/sfr_rx_parser.sv
// Frame parser: tracks reception, header, running sum and tick timeout.
// Depends on sfr_pkg; drives the payload memory write port.
`timescale 1ns / 1ps

module sfr_rx_parser #(
   parameter int PAYLOAD_BYTES = 16,
   localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  sfr_pkg::sfr_req_type   req,
   input  logic [15:0]            default_ticks,
   output sfr_pkg::sfr_event_type evt,
   output sfr_pkg::sfr_header_type header,
   output logic                   wr_en,
   output logic [IDX_W-1:0]       wr_addr,
   output logic [7:0]             wr_data
);
   import sfr_pkg::*;

   localparam int SUM_END   = PAYLOAD_START + PAYLOAD_BYTES;
   localparam int FRAME_END = SUM_END + 2;
   localparam int POS_W     = $clog2(FRAME_END);

   logic             armed_ff, armed_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      sum_ff, sum_in;
   logic             prefix_good_ff, prefix_good_in;
   logic [15:0]      elapsed_ff, elapsed_in;
   logic [15:0]      limit_ff, limit_in;
   sfr_header_type   header_ff, header_in;
   logic [7:0]       cklow_ff, cklow_in;
   logic [POS_W-1:0] payload_off;
   logic [7:0]       b;

   assign b           = req.rx_byte;
   assign payload_off = pos_ff - POS_W'(PAYLOAD_START);
   assign header      = header_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         pos_ff         <= '0;
         sum_ff         <= '0;
         prefix_good_ff <= 1'b1;
         elapsed_ff     <= '0;
         limit_ff       <= '0;
      end else begin
         armed_ff       <= armed_in;
         pos_ff         <= pos_in;
         sum_ff         <= sum_in;
         prefix_good_ff <= prefix_good_in;
         elapsed_ff     <= elapsed_in;
         limit_ff       <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      header_ff <= header_in;
      cklow_ff  <= cklow_in;
   end

   always_comb begin
      armed_in       = armed_ff;
      pos_in         = pos_ff;
      sum_in         = sum_ff;
      prefix_good_in = prefix_good_ff;
      elapsed_in     = elapsed_ff;
      limit_in       = limit_ff;
      header_in      = header_ff;
      cklow_in       = cklow_ff;
      evt            = '0;
      evt.armed      = armed_ff;
      wr_en          = 1'b0;
      wr_addr        = payload_off[IDX_W-1:0];
      wr_data        = b;
      if (accept) begin
         case (req.req_type)
            REQ_START: begin
               armed_in       = 1'b1;
               pos_in         = '0;
               sum_in         = '0;
               prefix_good_in = 1'b1;
               elapsed_in     = '0;
               limit_in       = (req.timeout_ticks != 16'd0) ? req.timeout_ticks
                                                              : default_ticks;
            end
            REQ_TICK: begin
               if (armed_ff) begin
                  if (elapsed_ff == limit_ff) begin
                     armed_in   = 1'b0;
                     evt.error  = 1'b1;
                     evt.status = STATUS_TIMEOUT;
                  end else begin
                     elapsed_in = elapsed_ff + 16'd1;
                  end
               end
            end
            REQ_BYTE: begin
               if (armed_ff) begin
                  if (pos_ff == POS_W'(POS_PREFIX_FIRST) && b != PREFIX_FIRST) begin
                     prefix_good_in = 1'b0;
                  end
                  if (pos_ff == POS_W'(POS_PREFIX_SECOND) && b != PREFIX_SECOND) begin
                     prefix_good_in = 1'b0;
                  end
                  if (pos_ff == POS_W'(POS_ADDRESS)) begin
                     header_in.address = b;
                  end else if (pos_ff == POS_W'(POS_COMMAND)) begin
                     header_in.command = b;
                  end else if (pos_ff == POS_W'(POS_LENGTH)) begin
                     header_in.length = b;
                  end else if (pos_ff >= POS_W'(PAYLOAD_START)
                               && pos_ff < POS_W'(SUM_END)) begin
                     wr_en = 1'b1;
                  end else if (pos_ff == POS_W'(SUM_END)) begin
                     cklow_in = b;
                  end
                  if (pos_ff < POS_W'(SUM_END)) begin
                     sum_in = sum_ff + {8'h00, b};
                  end
                  if (pos_ff == POS_W'(FRAME_END - 1)) begin
                     armed_in = 1'b0;
                     if (!prefix_good_ff) begin
                        evt.error  = 1'b1;
                        evt.status = STATUS_PREFIX;
                     end else if ({b, cklow_ff} != sum_ff) begin
                        evt.error  = 1'b1;
                        evt.status = STATUS_CHECKSUM;
                     end else begin
                        evt.good = 1'b1;
                     end
                  end else begin
                     pos_in = pos_ff + POS_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// File: design/sfr_payload_ram.sv
// Payload byte memory: one write port, one registered read port.
// Depends on nothing; written by the parser, read by the result stage.
`timescale 1ns / 1ps

module sfr_payload_ram #(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// File: design/sfr_rsp_stage.sv
// Result stage: output register, error results and the payload drain sequencer.
// Depends on sfr_pkg; reads the payload memory one byte per result.
`timescale 1ns / 1ps

module sfr_rsp_stage #(
   parameter int PAYLOAD_BYTES = 16,
   localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sfr_pkg::sfr_event_type  evt,
   input  sfr_pkg::sfr_header_type header,
   input  logic [7:0]              rd_data,
   input  logic                    rsp_ready,
   output logic [IDX_W-1:0]        rd_addr,
   output logic                    rsp_valid,
   output sfr_pkg::sfr_rsp_type    rsp_data,
   output logic                    busy
);
   import sfr_pkg::*;

   sfr_out_state_type state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              valid_ff, valid_in;
   sfr_rsp_type       data_ff, data_in;
   logic              slot_free;
   logic              last_idx;
   logic [IDX_W+3:0]  idx_wide;

   assign slot_free = !valid_ff || rsp_ready;
   assign last_idx  = idx_ff == IDX_W'(PAYLOAD_BYTES - 1);
   assign idx_wide  = {4'b0000, idx_ff};
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
   assign busy      = state_ff == OUT_DRAIN;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OUT_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      valid_in = rsp_ready ? 1'b0 : valid_ff;
      data_in  = data_ff;
      rd_addr  = '0;
      unique case (state_ff)
         OUT_IDLE: begin
            idx_in = '0;
            if (evt.error) begin
               valid_in              = 1'b1;
               data_in               = '0;
               data_in.frame_status  = evt.status;
               data_in.last          = 1'b1;
            end
            if (evt.good) begin
               state_in = OUT_DRAIN;
            end
         end
         OUT_DRAIN: begin
            rd_addr = idx_ff;
            if (slot_free) begin
               valid_in                = 1'b1;
               data_in.frame_status    = STATUS_OK;
               data_in.device_address  = header.address;
               data_in.command_code    = header.command;
               data_in.payload_length  = header.length;
               data_in.byte_index      = idx_wide[3:0];
               data_in.payload_byte    = rd_data;
               data_in.last            = last_idx;
               if (last_idx) begin
                  state_in = OUT_IDLE;
                  idx_in   = '0;
                  rd_addr  = '0;
               end else begin
                  idx_in  = idx_ff + IDX_W'(1);
                  rd_addr = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = OUT_IDLE;
         end
      endcase
   end

endmodule

// File: design/sensor_frame_receiver_unit.sv
// Top level of the sensor frame receiver: channels, timeout register and wiring.
// Depends on sfr_pkg, sfr_chan_if, sfr_rx_parser, sfr_payload_ram, sfr_rsp_stage.
`timescale 1ns / 1ps

// Usage:
// The req channel carries start, byte and tick items; the rsp channel returns
// results; the csr channel writes the default tick limit (reset value 1000),
// which a start item uses when it gives zero.
// Start, byte and tick items may follow back to back while req is ready. An item
// that ends a frame with an error, or a tick that times out, shows its single
// result on rsp in the cycle after it is taken.
// A good frame yields PAYLOAD_BYTES results: the first once the drain state is
// entered and the output register loaded, then one per cycle while rsp is ready.
// The drain reads the payload memory one byte per cycle while rsp is ready, and req
// is held not ready until the last of these results is in the output register.
// When rsp stalls, the output register holds its result and req stays not ready
// until the result is taken. The csr channel is always ready.
// Reset is synchronous: it disarms reception, empties the output register and
// restores the default tick limit. The payload memory needs no clearing pass.

module sensor_frame_receiver_unit #(
   parameter int PAYLOAD_BYTES = 16
) (
   input logic        clock,
   input logic        reset,
   sfr_chan_if.sink   req_if,
   sfr_chan_if.source rsp_if,
   sfr_chan_if.sink   csr_if
);
   import sfr_pkg::*;

   localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

   logic [15:0]      default_ticks_ff;
   logic             accept;
   logic             busy;
   logic             slot_free;
   sfr_event_type    evt;
   sfr_header_type   header;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [7:0]       rd_data;

   assign slot_free     = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready  = !busy && slot_free;
   assign accept        = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_ticks_ff <= DEFAULT_TIMEOUT_RESET;
      end else if (csr_if.valid) begin
         default_ticks_ff <= csr_if.data.default_timeout_ticks;
      end
   end

   sfr_rx_parser #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .req           (req_if.data),
      .default_ticks (default_ticks_ff),
      .evt           (evt),
      .header        (header),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   sfr_payload_ram #(
      .DEPTH(PAYLOAD_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sfr_rsp_stage #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_rsp (
      .clock     (clock),
      .reset     (reset),
      .evt       (evt),
      .header    (header),
      .rd_data   (rd_data),
      .rsp_ready (rsp_if.ready),
      .rd_addr   (rd_addr),
      .rsp_valid (rsp_if.valid),
      .rsp_data  (rsp_if.data),
      .busy      (busy)
   );

   // Error results carry only their status and close the frame.
   a_error_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.data.frame_status != STATUS_OK
      |-> rsp_if.data.last && rsp_if.data.payload_byte == 8'd0
          && rsp_if.data.byte_index == 4'd0)
      else $error("error result with payload fields set");

   // Reception cannot be armed again while a good frame is being drained.
   a_drain_disarmed: assert property (@(posedge clock) disable iff (reset)
      busy |-> !evt.armed)
      else $error("parser armed during payload drain");

   // A good frame always starts the drain on the next cycle.
   a_good_starts_drain: assert property (@(posedge clock) disable iff (reset)
      evt.good |=> busy)
      else $error("good frame did not start the drain");

endmodule

// File: tb/sfr_frame_checker.sv
// Checker for the sensor frame receiver: watches the req, rsp and csr channels,
// predicts every result item and compares it field by field with the block.
// Depends on sfr_pkg for the item types, request codes and frame constants.
`timescale 1ns / 1ps

module sfr_frame_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  sfr_pkg::sfr_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sfr_pkg::sfr_rsp_type rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  sfr_pkg::sfr_csr_type csr_data,
   output int                   fail_count,
   output int                   pending_count,
   output int                   results_seen,
   output int                   good_frames,
   output int                   error_frames
);
   import sfr_pkg::*;

   localparam int PAYLOAD_BYTES = 16;
   localparam int SUM_END       = PAYLOAD_START + PAYLOAD_BYTES;
   localparam int FRAME_BYTES   = SUM_END + 2;
   localparam int PRINT_LIMIT   = 40;

   logic [15:0]    default_limit;
   logic [15:0]    tick_limit;
   logic [15:0]    elapsed;
   logic [15:0]    byte_sum;
   logic           armed;
   logic           prefix_ok;
   logic [4:0]     frame_pos;
   sfr_header_type header;
   logic [7:0]     payload_mem [PAYLOAD_BYTES];
   logic [7:0]     checksum_low;
   sfr_rsp_type    frame_results_q [$];

   task automatic report_mismatch(input string what, input logic [15:0] got_v,
                                  input logic [15:0] want_v);
      if (fail_count < PRINT_LIMIT) begin
         $display("%0t checker: %s got %0h want %0h", $time, what, got_v, want_v);
      end
      fail_count++;
   endtask

   task automatic queue_error(input sfr_status_type status);
      sfr_rsp_type r;
      r = '0;
      r.frame_status = status;
      r.last = 1'b1;
      frame_results_q.push_back(r);
      armed = 1'b0;
      error_frames++;
   endtask

   task automatic predict_frame_step(input sfr_req_type item);
      int          pos;
      logic [7:0]  b;
      sfr_rsp_type r;
      b = item.rx_byte;
      pos = frame_pos;
      case (item.req_type)
         REQ_START: begin
            armed = 1'b1;
            frame_pos = '0;
            byte_sum = '0;
            prefix_ok = 1'b1;
            elapsed = '0;
            tick_limit = (item.timeout_ticks != 16'd0) ? item.timeout_ticks : default_limit;
         end
         REQ_TICK: begin
            if (armed) begin
               if (elapsed == tick_limit) begin
                  queue_error(STATUS_TIMEOUT);
               end else begin
                  elapsed = elapsed + 16'd1;
               end
            end
         end
         REQ_BYTE: begin
            if (armed) begin
               if (pos == POS_PREFIX_FIRST && b != PREFIX_FIRST) prefix_ok = 1'b0;
               if (pos == POS_PREFIX_SECOND && b != PREFIX_SECOND) prefix_ok = 1'b0;
               if (pos == POS_ADDRESS) begin
                  header.address = b;
               end else if (pos == POS_COMMAND) begin
                  header.command = b;
               end else if (pos == POS_LENGTH) begin
                  header.length = b;
               end else if (pos >= PAYLOAD_START && pos < SUM_END) begin
                  payload_mem[pos - PAYLOAD_START] = b;
               end else if (pos == SUM_END) begin
                  checksum_low = b;
               end
               if (pos < SUM_END) byte_sum = byte_sum + {8'd0, b};
               if (pos + 1 < FRAME_BYTES) begin
                  frame_pos = 5'(pos + 1);
               end else if (!prefix_ok) begin
                  queue_error(STATUS_PREFIX);
               end else if ({b, checksum_low} != byte_sum) begin
                  queue_error(STATUS_CHECKSUM);
               end else begin
                  for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                     r.frame_status   = STATUS_OK;
                     r.device_address = header.address;
                     r.command_code   = header.command;
                     r.payload_length = header.length;
                     r.byte_index     = 4'(k);
                     r.payload_byte   = payload_mem[k];
                     r.last           = (k == PAYLOAD_BYTES - 1);
                     frame_results_q.push_back(r);
                  end
                  armed = 1'b0;
                  good_frames++;
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_result(input sfr_rsp_type got);
      sfr_rsp_type want;
      results_seen++;
      if (frame_results_q.size() == 0) begin
         report_mismatch("result item with nothing expected, status", got.frame_status, 0);
      end else begin
         want = frame_results_q.pop_front();
         if (got.frame_status !== want.frame_status)
            report_mismatch("frame_status", got.frame_status, want.frame_status);
         if (got.device_address !== want.device_address)
            report_mismatch("device_address", got.device_address, want.device_address);
         if (got.command_code !== want.command_code)
            report_mismatch("command_code", got.command_code, want.command_code);
         if (got.payload_length !== want.payload_length)
            report_mismatch("payload_length", got.payload_length, want.payload_length);
         if (got.byte_index !== want.byte_index)
            report_mismatch("byte_index", got.byte_index, want.byte_index);
         if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", got.payload_byte, want.payload_byte);
         if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         default_limit = DEFAULT_TIMEOUT_RESET;
         tick_limit = '0;
         elapsed = '0;
         byte_sum = '0;
         armed = 1'b0;
         prefix_ok = 1'b1;
         frame_pos = '0;
         frame_results_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) predict_frame_step(req_data);
         if (csr_valid && csr_ready) default_limit = csr_data.default_timeout_ticks;
      end
      pending_count = frame_results_q.size();
   end

endmodule

// File: tb/tb.sv
// Top of the sensor frame receiver testbench: clock, reset, stimulus and verdict.
// Depends on sfr_pkg, sfr_chan_if, sensor_frame_receiver_unit and sfr_frame_checker.
`timescale 1ns / 1ps

module tb;
   import sfr_pkg::*;

   localparam int          PAYLOAD_BYTES     = 16;
   localparam int          SUM_END           = PAYLOAD_START + PAYLOAD_BYTES;
   localparam int          FRAME_BYTES       = SUM_END + 2;
   localparam logic [1:0]  REQ_UNUSED        = 2'd3;
   localparam int          ITEM_TARGET       = 370;
   localparam int          PHASE_COUNT       = 4;
   localparam int          LONG_STALL_CYCLES = 120;

   typedef enum int {
      FLAW_NONE,
      FLAW_PREFIX,
      FLAW_CHECKSUM,
      FLAW_CUT
   } frame_flaw_type;

   logic clock;
   logic reset;

   sfr_chan_if #(.data_type(sfr_req_type)) req_ch ();
   sfr_chan_if #(.data_type(sfr_rsp_type)) rsp_ch ();
   sfr_chan_if #(.data_type(sfr_csr_type)) csr_ch ();

   int          fail_count;
   int          pending_count;
   int          results_seen;
   int          good_frames;
   int          error_frames;
   int          items_sent;
   int          long_stalls;
   bit          sender_idle_on;
   bit          receiver_idle_on;
   bit          long_stall_request;
   logic [15:0] cur_default;

   sensor_frame_receiver_unit #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   sfr_frame_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_data      (req_ch.data),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_data      (rsp_ch.data),
      .csr_valid     (csr_ch.valid),
      .csr_ready     (csr_ch.ready),
      .csr_data      (csr_ch.data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .results_seen  (results_seen),
      .good_frames   (good_frames),
      .error_frames  (error_frames)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(negedge clock);
            long_stall_request = 1'b0;
            long_stalls++;
            rsp_ch.ready <= 1'b1;
         end else if (receiver_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic push_item(input logic [1:0] kind, input logic [7:0] rx_byte,
                            input logic [15:0] ticks);
      sfr_req_type item;
      item.req_type = kind;
      item.rx_byte = rx_byte;
      item.timeout_ticks = ticks;
      if (sender_idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= item;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_results_drained();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_default_limit(input logic [15:0] value);
      req_ch.valid <= 1'b0;
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      cur_default = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_frame(input frame_flaw_type flaw, input logic [15:0] limit,
                             input int tick_odds, input bit extreme_fill);
      logic [7:0]  fb [FRAME_BYTES];
      logic [15:0] sum;
      int          count;
      fb[POS_PREFIX_FIRST] = PREFIX_FIRST;
      fb[POS_PREFIX_SECOND] = PREFIX_SECOND;
      for (int i = POS_ADDRESS; i < SUM_END; i++) begin
         fb[i] = extreme_fill ? ((i % 2 == 0) ? 8'hFF : 8'h00) : 8'($urandom);
      end
      if (!extreme_fill && $urandom_range(0, 1) == 0) fb[POS_LENGTH] = 8'($urandom_range(0, 16));
      if (flaw == FLAW_PREFIX) begin
         fb[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      end
      sum = '0;
      for (int i = 0; i < SUM_END; i++) sum += {8'd0, fb[i]};
      fb[SUM_END] = sum[7:0];
      fb[SUM_END + 1] = sum[15:8];
      if (flaw == FLAW_CHECKSUM || (flaw == FLAW_PREFIX && $urandom_range(0, 1) == 0)) begin
         fb[SUM_END + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
      end
      count = (flaw == FLAW_CUT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
      push_item(REQ_START, 8'($urandom), limit);
      for (int i = 0; i < count; i++) begin
         if (tick_odds != 0 && $urandom_range(0, tick_odds - 1) == 0) begin
            push_item(REQ_TICK, 8'($urandom), 16'($urandom));
         end
         push_item(REQ_BYTE, fb[i], 16'($urandom));
      end
   endtask

   task automatic send_timeout_run();
      logic [15:0] limit;
      int          allowed;
      if (cur_default <= 16'd6 && $urandom_range(0, 1) == 0) begin
         limit = 16'd0;
         allowed = cur_default;
      end else begin
         limit = 16'($urandom_range(1, 6));
         allowed = limit;
      end
      push_item(REQ_START, 8'($urandom), limit);
      for (int i = 0; i <= allowed; i++) begin
         if ($urandom_range(0, 3) == 0) push_item(REQ_BYTE, 8'($urandom), 16'($urandom));
         push_item(REQ_TICK, 8'($urandom), 16'($urandom));
      end
   endtask

   task automatic run_random_episode(input bit quiet);
      int          pick;
      logic [15:0] limit;
      int          odds;
      sender_idle_on = !quiet && ($urandom_range(0, 3) != 0);
      receiver_idle_on = !quiet && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      limit = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
      odds = (limit == 16'd0 && cur_default < 16'd8 && $urandom_range(0, 1) == 0) ? 0 : 10;
      if (pick < 55) begin
         send_frame(FLAW_NONE, limit, odds, 1'b0);
      end else if (pick < 65) begin
         send_frame(FLAW_PREFIX, limit, odds, 1'b0);
      end else if (pick < 75) begin
         send_frame(FLAW_CHECKSUM, limit, odds, 1'b0);
      end else if (pick < 83) begin
         send_frame(FLAW_CUT, limit, odds, 1'b0);
      end else if (pick < 92) begin
         send_timeout_run();
      end else begin
         repeat ($urandom_range(1, 4)) begin
            push_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      logic [15:0] phase_limit [PHASE_COUNT];
      int          phase_end;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      long_stall_request = 1'b0;
      cur_default = DEFAULT_TIMEOUT_RESET;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_item(REQ_BYTE, 8'hFF, 16'hFFFF);
      push_item(REQ_TICK, 8'h00, 16'h0000);
      push_item(REQ_UNUSED, 8'hA5, 16'h5A5A);
      write_default_limit(16'd0);
      push_item(REQ_START, 8'h00, 16'd0);
      push_item(REQ_TICK, 8'h00, 16'd0);
      wait_results_drained();
      write_default_limit(16'hFFFF);
      send_frame(FLAW_NONE, 16'hFFFF, 0, 1'b1);
      push_item(REQ_START, 8'h00, 16'd1);
      push_item(REQ_TICK, 8'h00, 16'd0);
      push_item(REQ_TICK, 8'h00, 16'd0);
      wait_results_drained();

      phase_limit[0] = 16'hFFFF;
      phase_limit[1] = 16'd1;
      phase_limit[2] = 16'($urandom_range(2, 65534));
      phase_limit[3] = 16'd4;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_results_drained();
         write_default_limit(phase_limit[p]);
         phase_end = items_sent + (ITEM_TARGET - items_sent) / (PHASE_COUNT - p);
         if (p == 0) begin
            long_stall_request = 1'b1;
            send_frame(FLAW_NONE, 16'd0, 0, 1'b0);
            send_frame(FLAW_NONE, 16'd0, 0, 1'b0);
         end
         while (items_sent < phase_end) run_random_episode(p == PHASE_COUNT - 1);
      end

      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("tb: %0d items sent, %0d results checked (%0d good frames, %0d error results)",
               items_sent, results_seen, good_frames, error_frames);
      $display("tb: %0d register settings incl. 0, 1 and 65535; %0d long output stalls",
               PHASE_COUNT + 2, long_stalls);
      if (fail_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// File: files.f
design/sfr_pkg.sv
design/sfr_chan_if.sv
design/sfr_rx_parser.sv
design/sfr_payload_ram.sv
design/sfr_rsp_stage.sv
design/sensor_frame_receiver_unit.sv
tb/sfr_frame_checker.sv
tb/tb.sv
